// File: src/aes256_pkg.sv
// Shared types, constants and GF(2^8) helpers for the AES-256 pipeline.
`default_nettype none
package aes256_pkg;

    localparam int ROUND_COUNT = 14;
    localparam int KEY_WORDS   = 8;
    localparam int TOTAL_WORDS = 4 * (ROUND_COUNT + 1);
    localparam int CNT_W       = $clog2(TOTAL_WORDS);

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [1:0] REG_KEY_WORD0 = 2'd0;
    localparam logic [1:0] REG_KEY_WORD1 = 2'd1;
    localparam logic [1:0] REG_KEY_WORD2 = 2'd2;
    localparam logic [1:0] REG_KEY_WORD3 = 2'd3;

    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1b;

    typedef logic [127:0] state_t;

    typedef struct packed {
        logic   valid;
        logic   cmd;
        state_t data;
    } stage_t;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return b[7] ? ({b[6:0], 1'b0} ^ GF_POLY) : {b[6:0], 1'b0};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
    endfunction

    // byte i of the state sits at bits [127-8i -: 8]; byte 4c+r is row r, column c
    function automatic state_t sub_bytes(input state_t s, input logic inv);
        state_t t;
        for (int i = 0; i < 16; i++) begin
            t[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : FWD_SBOX[s[127-8*i -: 8]];
        end
        return t;
    endfunction

    function automatic state_t shift_rows(input state_t s, input logic inv);
        state_t t;
        int src;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
                t[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
            end
        end
        return t;
    endfunction

    function automatic state_t mix_columns(input state_t s);
        state_t t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            t[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

    function automatic logic [7:0] mul9(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ a;
    endfunction

    function automatic logic [7:0] mul11(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
    endfunction

    function automatic logic [7:0] mul13(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
    endfunction

    function automatic logic [7:0] mul14(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
    endfunction

    function automatic state_t inv_mix_columns(input state_t s);
        state_t t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            t[127-32*c -: 8] = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
            t[119-32*c -: 8] = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
            t[111-32*c -: 8] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
            t[103-32*c -: 8] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// File: src/aes256_block_cipher.sv
// AES-256 ECB encrypt/decrypt: whitening stage plus fourteen pipelined rounds.
// A register follows the whitening stage and each round.
// Throughput: one block per cycle outside key expansion; the whole pipeline holds while a result waits on m_tready.
// Reset and every key write start the key expansion, s_tready low meanwhile.
// Reset clears valid bits and key registers; round keys are rebuilt from the zero key.
`default_nettype none
module aes256_block_cipher (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // block_high [63:0], block_low [127:64]
    input  wire logic         s_tuser,   // command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // result_high [63:0], result_low [127:64]
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [63:0]  cfg_wdata
);
    import aes256_pkg::*;

    state_t round_key [ROUND_COUNT + 1];
    logic   busy;
    logic   en;
    stage_t stage [ROUND_COUNT + 1];
    logic   v0_reg;
    logic   c0_reg;
    state_t d0_reg;
    state_t blk;

    aes256_key_sched u_key_sched (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .round_key (round_key),
        .busy      (busy)
    );

    assign en       = !stage[ROUND_COUNT].valid || m_tready;
    assign s_tready = en && !busy;
    assign blk      = {s_tdata[63:0], s_tdata[127:64]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid && !busy;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c0_reg <= s_tuser;
            d0_reg <= blk ^ ((s_tuser == CMD_DECRYPT) ? round_key[ROUND_COUNT] : round_key[0]);
        end
    end

    assign stage[0] = '{valid: v0_reg, cmd: c0_reg, data: d0_reg};

    for (genvar j = 1; j <= ROUND_COUNT; j++) begin : g_round
        aes256_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .last      (j == ROUND_COUNT),
            .rk_enc    (round_key[j]),
            .rk_dec    (round_key[ROUND_COUNT - j]),
            .stage_in  (stage[j-1]),
            .stage_out (stage[j])
        );
    end

    assign m_tvalid = stage[ROUND_COUNT].valid;
    assign m_tdata  = {stage[ROUND_COUNT].data[63:0], stage[ROUND_COUNT].data[127:64]};

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready)
        else $error("input taken during key expansion");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline held");

endmodule
`default_nettype wire

// File: src/aes256_key_sched.sv
// Key registers and sequential AES-256 key expansion, one round-key word per cycle.
`default_nettype none
module aes256_key_sched (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [1:0]            cfg_addr,
    input  wire logic [63:0]           cfg_wdata,
    output aes256_pkg::state_t         round_key [aes256_pkg::ROUND_COUNT + 1],
    output logic                       busy
);
    import aes256_pkg::*;

    logic [63:0]      key_reg [4];
    logic [31:0]      rk_reg  [TOTAL_WORDS];
    logic [31:0]      win_reg [KEY_WORDS];
    logic [7:0]       rc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [31:0]      t_word;
    logic [31:0]      new_word;

    always_comb begin
        t_word = win_reg[KEY_WORDS-1];
        if (cnt_reg[2:0] == 3'd0) begin
            t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {rc_reg, 24'd0};
        end else if (cnt_reg[2:0] == 3'd4) begin
            t_word = sub_word(t_word);
        end
        new_word = win_reg[0] ^ t_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (cfg_wr_en) begin
            key_reg[cfg_addr] <= cfg_wdata;
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                for (int i = 0; i < KEY_WORDS; i++) begin
                    win_reg[i] <= i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
                    rk_reg[i]  <= i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
                end
                rc_reg  <= RCON_FIRST;
                cnt_reg <= CNT_W'(KEY_WORDS);
            end else begin
                rk_reg[cnt_reg] <= new_word;
                for (int i = 0; i < KEY_WORDS - 1; i++) win_reg[i] <= win_reg[i+1];
                win_reg[KEY_WORDS-1] <= new_word;
                if (cnt_reg[2:0] == 3'd0) rc_reg <= xtime(rc_reg);
                if (cnt_reg == CNT_W'(TOTAL_WORDS - 1)) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r <= ROUND_COUNT; r++) begin
            round_key[r] = {rk_reg[4*r], rk_reg[4*r+1], rk_reg[4*r+2], rk_reg[4*r+3]};
        end
    end

    assign busy = busy_reg;

endmodule
`default_nettype wire

// File: src/aes256_round.sv
// One registered cipher round, forward or inverse per request.
`default_nettype none
module aes256_round (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               last,
    input  aes256_pkg::state_t      rk_enc,
    input  aes256_pkg::state_t      rk_dec,
    input  aes256_pkg::stage_t      stage_in,
    output aes256_pkg::stage_t      stage_out
);
    import aes256_pkg::*;

    state_t enc_s, dec_s, res;
    logic   valid_reg;
    logic   cmd_reg;
    state_t data_reg;

    always_comb begin
        enc_s = shift_rows(sub_bytes(stage_in.data, 1'b0), 1'b0);
        if (!last) enc_s = mix_columns(enc_s);
        enc_s = enc_s ^ rk_enc;
        dec_s = sub_bytes(shift_rows(stage_in.data, 1'b1), 1'b1) ^ rk_dec;
        if (!last) dec_s = inv_mix_columns(dec_s);
        res = (stage_in.cmd == CMD_DECRYPT) ? dec_s : enc_s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd_reg  <= stage_in.cmd;
            data_reg <= res;
        end
    end

    assign stage_out = '{valid: valid_reg, cmd: cmd_reg, data: data_reg};

endmodule
`default_nettype wire
